@@ rtl/core/dwvg_pkg.sv @@
// ----------------------------------------------------------------------------
// dwvg_pkg - shared types and constants of the velocity grid core
// Item and queue entry types, divider request/response, register codes,
// back-end sequencer states and the bin count helper.
// ----------------------------------------------------------------------------
`default_nettype none

package dwvg_pkg;

	// Field widths fixed by the item and register layout
	localparam int SPEED_W  = 32;
	localparam int LIMIT_W  = 31;
	localparam int BINS_W   = 11;
	localparam int PERIOD_W = 16;
	localparam int STEP_W   = 31;
	localparam int IDX_W    = 12;
	localparam int CFG_W    = 31;
	localparam int CFG_IDX_W = 3;

	// Period is unsigned Q0.16
	localparam int PERIOD_FRAC = 16;

	// Grid counts saturate here
	localparam int MAX_BINS = 1024;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Shared multiplier: 32 x 16 bits
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 16;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Shared restoring divider
	localparam int DIV_NUM_W    = 44;
	localparam int DIV_DEN_W    = 32;
	localparam int DIV_QUO_W    = 33;
	localparam int DIV_NARROW_W = 11;
	localparam int DIV_CNT_W    = $clog2(DIV_QUO_W + 1);

	// Register reset values
	localparam logic [BINS_W-1:0]   BINS_RST   = BINS_W'(100);
	localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(655);
	localparam logic [BINS_W-1:0]   BINS_ONE   = BINS_W'(1);

	localparam logic signed [IDX_W-1:0] IDX_NONE = '1;
	localparam logic signed [IDX_W-1:0] IDX_ZERO = '0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACCEL       = 3'd0,
		REG_BRAKE       = 3'd1,
		REG_FORWARD     = 3'd2,
		REG_TURN_RATE   = 3'd3,
		REG_TURN_ACCEL  = 3'd4,
		REG_SPEED_BINS  = 3'd5,
		REG_TURN_BINS   = 3'd6,
		REG_PERIOD      = 3'd7
	} cfg_reg_t;

	typedef enum logic {
		OP_UPDATE = 1'b0,
		OP_QUERY  = 1'b1
	} op_kind_t;

	typedef struct packed {
		op_kind_t                   kind;
		logic signed [SPEED_W-1:0]  lin;
		logic signed [SPEED_W-1:0]  ang;
	} op_t;

	typedef struct packed {
		logic [LIMIT_W-1:0]  accel;
		logic [LIMIT_W-1:0]  brake;
		logic [LIMIT_W-1:0]  fwd;
		logic [LIMIT_W-1:0]  tlim;
		logic [LIMIT_W-1:0]  taccel;
		logic [BINS_W-1:0]   speed_bins;
		logic [BINS_W-1:0]   turn_bins;
		logic [PERIOD_W-1:0] period;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic                 start;
		logic                 narrow;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_QUO_W-1:0] quo;
	} div_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MUL_BRAKE,
		ST_MUL_ACCEL,
		ST_MUL_TURN,
		ST_WINDOW,
		ST_ORDER,
		ST_STEP_SPEED,
		ST_WAIT_SPEED,
		ST_STEP_TURN,
		ST_WAIT_TURN,
		ST_CHECK,
		ST_ROW_MUL,
		ST_ROW_DIV,
		ST_WAIT_ROW,
		ST_COL_MUL,
		ST_COL_DIV,
		ST_WAIT_COL,
		ST_RESULT
	} back_st_t;

	// Zero bins count as one, large values saturate
	function automatic logic [BINS_W-1:0] eff_bins(input logic [BINS_W-1:0] b);
		logic [BINS_W-1:0] r;
		r = b;
		if (b == '0) begin
			r = BINS_ONE;
		end else if (32'(b) > MAX_BINS) begin
			r = BINS_W'(MAX_BINS);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/dwvg_front.sv @@
// ----------------------------------------------------------------------------
// dwvg_front - request intake
// Registers one request, classifies it and clamps update speeds to limits.
// ----------------------------------------------------------------------------
`default_nettype none

module dwvg_front (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                kind,
	input  wire logic signed [dwvg_pkg::SPEED_W-1:0] linear_speed,
	input  wire logic signed [dwvg_pkg::SPEED_W-1:0] angular_speed,
	input  wire dwvg_pkg::cfg_t                      cfg,
	input  wire dwvg_pkg::q_stat_t                   q_stat,
	output logic                                     push,
	output dwvg_pkg::op_t                            push_data
);

	logic          valid_s1;
	dwvg_pkg::op_t op_s1;
	dwvg_pkg::op_t op_c;
	logic          accept;

	logic signed [dwvg_pkg::SPEED_W-1:0] fwd_s;
	logic signed [dwvg_pkg::SPEED_W-1:0] tlim_s;
	logic signed [dwvg_pkg::SPEED_W-1:0] tlim_n;

	assign fwd_s  = $signed({1'b0, cfg.fwd});
	assign tlim_s = $signed({1'b0, cfg.tlim});
	assign tlim_n = -tlim_s;

	assign push     = valid_s1 && !q_stat.full;
	assign in_stall = valid_s1 && q_stat.full;
	assign accept   = in_valid && !in_stall;
	assign push_data = op_s1;

	// Clamp measured speeds for an update; pass query candidates untouched
	always_comb begin
		op_c.kind = dwvg_pkg::op_kind_t'(kind);
		op_c.lin  = linear_speed;
		op_c.ang  = angular_speed;
		if (op_c.kind == dwvg_pkg::OP_UPDATE) begin
			if (linear_speed < 0) begin
				op_c.lin = '0;
			end else if (linear_speed > fwd_s) begin
				op_c.lin = fwd_s;
			end
			if (angular_speed > tlim_s) begin
				op_c.ang = tlim_s;
			end else if (angular_speed < tlim_n) begin
				op_c.ang = tlim_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op_c;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/dwvg_queue.sv @@
// ----------------------------------------------------------------------------
// dwvg_queue - short request queue
// Decouples the intake stage from the back-end sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module dwvg_queue #(
	parameter int DEPTH = dwvg_pkg::QUEUE_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire dwvg_pkg::op_t      push_data,
	input  wire logic               pop,
	output dwvg_pkg::op_t           pop_data,
	output dwvg_pkg::q_stat_t       stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	dwvg_pkg::op_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
		return r;
	endfunction

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue popped while empty");

endmodule

`default_nettype wire

@@ rtl/core/dwvg_div.sv @@
// ----------------------------------------------------------------------------
// dwvg_div - shared restoring divider
// One quotient bit per cycle; wide mode gives 33 bits, narrow mode 11 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module dwvg_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dwvg_pkg::div_req_t req,
	output dwvg_pkg::div_rsp_t      rsp
);

	localparam int NW = dwvg_pkg::DIV_NUM_W;
	localparam int DW = dwvg_pkg::DIV_DEN_W;
	localparam int QW = dwvg_pkg::DIV_QUO_W;
	localparam int RW = dwvg_pkg::DIV_NARROW_W;
	localparam int CW = dwvg_pkg::DIV_CNT_W;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [QW-1:0] bits_q;
	logic [QW-1:0] quo_q;

	logic [DW:0]   trial;
	logic          fits;
	logic [DW:0]   diff;

	assign trial = {rem_q, bits_q[QW-1]};
	assign fits  = (trial >= {1'b0, den_q});
	assign diff  = trial - {1'b0, den_q};

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.narrow ? CW'(RW) : CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Narrow mode: the quotient is known to fit in RW bits, so the top of
	// the dividend is already below the divisor and seeds the remainder.
	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			quo_q <= '0;
			if (req.narrow) begin
				rem_q  <= req.num[NW-2:RW];
				bits_q <= {req.num[RW-1:0], {(QW-RW){1'b0}}};
			end else begin
				rem_q  <= DW'(req.num[NW-1:QW]);
				bits_q <= req.num[QW-1:0];
			end
		end else if (busy_q) begin
			rem_q  <= fits ? diff[DW-1:0] : trial[DW-1:0];
			bits_q <= {bits_q[QW-2:0], 1'b0};
			quo_q  <= {quo_q[QW-2:0], fits};
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");

endmodule

`default_nettype wire

@@ rtl/core/dwvg_back.sv @@
// ----------------------------------------------------------------------------
// dwvg_back - window update and grid lookup sequencer
// Holds the window state, drives the shared multiplier and divider and
// registers one result at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module dwvg_back (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire dwvg_pkg::cfg_t                         cfg,
	input  wire dwvg_pkg::op_t                          q_data,
	input  wire dwvg_pkg::q_stat_t                      q_stat,
	output logic                                        pop,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic signed [dwvg_pkg::SPEED_W-1:0]         speed_low,
	output logic signed [dwvg_pkg::SPEED_W-1:0]         speed_high,
	output logic signed [dwvg_pkg::SPEED_W-1:0]         turn_left,
	output logic signed [dwvg_pkg::SPEED_W-1:0]         turn_right,
	output logic        [dwvg_pkg::STEP_W-1:0]          speed_increment,
	output logic        [dwvg_pkg::STEP_W-1:0]          turn_increment,
	output logic        [dwvg_pkg::BINS_W-1:0]          grid_rows,
	output logic        [dwvg_pkg::BINS_W-1:0]          grid_cols,
	output logic signed [dwvg_pkg::IDX_W-1:0]           row_index,
	output logic signed [dwvg_pkg::IDX_W-1:0]           col_index,
	output logic                                        outside_window
);

	localparam int SW = dwvg_pkg::SPEED_W;
	localparam int XW = SW + 2;
	localparam int LW = dwvg_pkg::LIMIT_W;
	localparam int PF = dwvg_pkg::PERIOD_FRAC;

	dwvg_pkg::back_st_t st_q, st_d;
	dwvg_pkg::div_req_t div_req;
	dwvg_pkg::div_rsp_t div_rsp;
	logic               out_load;

	dwvg_pkg::op_t op_q;

	// Window state
	logic signed [SW-1:0]               win_low_q, win_high_q, win_left_q, win_right_q;
	logic [dwvg_pkg::STEP_W-1:0]        step_speed_q, step_turn_q;
	logic [dwvg_pkg::BINS_W-1:0]        rows_q, cols_q;

	// Working registers
	logic [LW-1:0]                      delta_brake_q, delta_accel_q;
	logic [dwvg_pkg::MUL_P_W-1:0]       mul_q;
	logic                               err_q;
	logic signed [dwvg_pkg::IDX_W-1:0]  row_q, col_q;
	logic                               out_valid_q;

	// Shared multiplier
	logic [dwvg_pkg::MUL_A_W-1:0]       mul_a;
	logic [dwvg_pkg::MUL_B_W-1:0]       mul_b;
	logic [dwvg_pkg::MUL_P_W-1:0]       mul_p;

	logic [SW-1:0] span_speed, span_turn, off_speed, off_turn;
	logic          speed_flat, turn_flat;
	logic          query_err;

	logic signed [XW-1:0] lin_x, ang_x, fwd_x, tlim_x, tlim_nx;
	logic signed [XW-1:0] brk_x, acc_x, trn_x;
	logic signed [XW-1:0] lo_raw, hi_raw, rt_raw, lf_raw;
	logic signed [XW-1:0] lo_c, hi_c, rt_c, lf_c;

	logic [LW-1:0] delta_turn;

	dwvg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Spans and offsets fit in 32 unsigned bits; wrap-around subtraction is exact
	assign span_speed = win_high_q - win_low_q;
	assign span_turn  = win_right_q - win_left_q;
	assign off_speed  = op_q.lin - win_low_q;
	assign off_turn   = op_q.ang - win_left_q;
	assign speed_flat = (win_high_q == win_low_q);
	assign turn_flat  = (win_right_q == win_left_q);

	assign query_err = (!speed_flat && (op_q.lin < win_low_q || op_q.lin > win_high_q))
		|| (!turn_flat && (op_q.ang < win_left_q || op_q.ang > win_right_q));

	assign delta_turn = mul_q[PF+LW-1:PF];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			dwvg_pkg::ST_MUL_BRAKE: begin
				mul_a = {1'b0, cfg.brake};
				mul_b = cfg.period;
			end
			dwvg_pkg::ST_MUL_ACCEL: begin
				mul_a = {1'b0, cfg.accel};
				mul_b = cfg.period;
			end
			dwvg_pkg::ST_MUL_TURN: begin
				mul_a = {1'b0, cfg.taccel};
				mul_b = cfg.period;
			end
			dwvg_pkg::ST_ROW_MUL: begin
				mul_a = off_speed;
				mul_b = dwvg_pkg::MUL_B_W'(cfg.speed_bins);
			end
			dwvg_pkg::ST_COL_MUL: begin
				mul_a = off_turn;
				mul_b = dwvg_pkg::MUL_B_W'(cfg.turn_bins);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = dwvg_pkg::MUL_P_W'(mul_a) * dwvg_pkg::MUL_P_W'(mul_b);

	// Reachable window, clamped to the limits
	always_comb begin
		lin_x   = {{2{op_q.lin[SW-1]}}, op_q.lin};
		ang_x   = {{2{op_q.ang[SW-1]}}, op_q.ang};
		fwd_x   = $signed({3'b000, cfg.fwd});
		tlim_x  = $signed({3'b000, cfg.tlim});
		tlim_nx = -tlim_x;
		brk_x   = $signed({3'b000, delta_brake_q});
		acc_x   = $signed({3'b000, delta_accel_q});
		trn_x   = $signed({3'b000, delta_turn});

		lo_raw = lin_x - brk_x;
		hi_raw = lin_x + acc_x;
		rt_raw = ang_x + trn_x;
		lf_raw = ang_x - trn_x;

		lo_c = lo_raw;
		if (lo_raw < 0) begin
			lo_c = '0;
		end else if (lo_raw > fwd_x) begin
			lo_c = fwd_x;
		end
		hi_c = hi_raw;
		if (hi_raw < 0) begin
			hi_c = '0;
		end else if (hi_raw > fwd_x) begin
			hi_c = fwd_x;
		end
		rt_c = (rt_raw > tlim_x) ? tlim_x : rt_raw;
		lf_c = (lf_raw < tlim_nx) ? tlim_nx : lf_raw;
	end

	// Next state and handshakes
	always_comb begin
		st_d     = st_q;
		pop      = 1'b0;
		out_load = 1'b0;
		div_req  = '0;
		case (st_q)
			dwvg_pkg::ST_IDLE: begin
				if (!q_stat.empty) begin
					pop  = 1'b1;
					st_d = (q_data.kind == dwvg_pkg::OP_UPDATE) ?
						dwvg_pkg::ST_MUL_BRAKE : dwvg_pkg::ST_CHECK;
				end
			end
			dwvg_pkg::ST_MUL_BRAKE: st_d = dwvg_pkg::ST_MUL_ACCEL;
			dwvg_pkg::ST_MUL_ACCEL: st_d = dwvg_pkg::ST_MUL_TURN;
			dwvg_pkg::ST_MUL_TURN:  st_d = dwvg_pkg::ST_WINDOW;
			dwvg_pkg::ST_WINDOW:    st_d = dwvg_pkg::ST_ORDER;
			dwvg_pkg::ST_ORDER:     st_d = dwvg_pkg::ST_STEP_SPEED;
			dwvg_pkg::ST_STEP_SPEED: begin
				div_req.start  = 1'b1;
				div_req.narrow = 1'b0;
				div_req.num    = dwvg_pkg::DIV_NUM_W'(span_speed);
				div_req.den    = dwvg_pkg::DIV_DEN_W'(cfg.speed_bins);
				st_d = dwvg_pkg::ST_WAIT_SPEED;
			end
			dwvg_pkg::ST_WAIT_SPEED: begin
				if (div_rsp.done) begin
					st_d = dwvg_pkg::ST_STEP_TURN;
				end
			end
			dwvg_pkg::ST_STEP_TURN: begin
				div_req.start  = 1'b1;
				div_req.narrow = 1'b0;
				div_req.num    = dwvg_pkg::DIV_NUM_W'(span_turn);
				div_req.den    = dwvg_pkg::DIV_DEN_W'(cfg.turn_bins);
				st_d = dwvg_pkg::ST_WAIT_TURN;
			end
			dwvg_pkg::ST_WAIT_TURN: begin
				if (div_rsp.done) begin
					st_d = dwvg_pkg::ST_RESULT;
				end
			end
			dwvg_pkg::ST_CHECK: st_d = dwvg_pkg::ST_ROW_MUL;
			dwvg_pkg::ST_ROW_MUL: begin
				st_d = (speed_flat || err_q) ? dwvg_pkg::ST_COL_MUL : dwvg_pkg::ST_ROW_DIV;
			end
			dwvg_pkg::ST_ROW_DIV: begin
				div_req.start  = 1'b1;
				div_req.narrow = 1'b1;
				div_req.num    = mul_q[dwvg_pkg::DIV_NUM_W-1:0];
				div_req.den    = span_speed;
				st_d = dwvg_pkg::ST_WAIT_ROW;
			end
			dwvg_pkg::ST_WAIT_ROW: begin
				if (div_rsp.done) begin
					st_d = dwvg_pkg::ST_COL_MUL;
				end
			end
			dwvg_pkg::ST_COL_MUL: begin
				st_d = (turn_flat || err_q) ? dwvg_pkg::ST_RESULT : dwvg_pkg::ST_COL_DIV;
			end
			dwvg_pkg::ST_COL_DIV: begin
				div_req.start  = 1'b1;
				div_req.narrow = 1'b1;
				div_req.num    = mul_q[dwvg_pkg::DIV_NUM_W-1:0];
				div_req.den    = span_turn;
				st_d = dwvg_pkg::ST_WAIT_COL;
			end
			dwvg_pkg::ST_WAIT_COL: begin
				if (div_rsp.done) begin
					st_d = dwvg_pkg::ST_RESULT;
				end
			end
			dwvg_pkg::ST_RESULT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					st_d     = dwvg_pkg::ST_IDLE;
				end
			end
			default: st_d = dwvg_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= dwvg_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// Window state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_low_q    <= '0;
			win_high_q   <= '0;
			win_left_q   <= '0;
			win_right_q  <= '0;
			step_speed_q <= '0;
			step_turn_q  <= '0;
			rows_q       <= dwvg_pkg::BINS_ONE;
			cols_q       <= dwvg_pkg::BINS_ONE;
			out_valid_q  <= 1'b0;
		end else begin
			case (st_q)
				dwvg_pkg::ST_WINDOW: begin
					win_low_q   <= lo_c[SW-1:0];
					win_high_q  <= hi_c[SW-1:0];
					win_left_q  <= lf_c[SW-1:0];
					win_right_q <= rt_c[SW-1:0];
				end
				dwvg_pkg::ST_ORDER: begin
					if (win_high_q < win_low_q) begin
						win_high_q <= win_low_q;
					end
					if (win_right_q < win_left_q) begin
						win_right_q <= win_left_q;
					end
				end
				dwvg_pkg::ST_WAIT_SPEED: begin
					if (div_rsp.done) begin
						step_speed_q <= div_rsp.quo[dwvg_pkg::STEP_W-1:0];
						rows_q <= (div_rsp.quo != '0 && win_high_q > win_low_q) ?
							cfg.speed_bins : dwvg_pkg::BINS_ONE;
					end
				end
				dwvg_pkg::ST_WAIT_TURN: begin
					if (div_rsp.done) begin
						// Saturate the turn step to 31 bits
						step_turn_q <= (|div_rsp.quo[dwvg_pkg::DIV_QUO_W-1:dwvg_pkg::STEP_W]) ?
							'1 : div_rsp.quo[dwvg_pkg::STEP_W-1:0];
						cols_q <= (div_rsp.quo != '0 && win_right_q > win_left_q) ?
							cfg.turn_bins : dwvg_pkg::BINS_ONE;
					end
				end
				default: begin
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers and result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			op_q  <= q_data;
			err_q <= 1'b0;
			row_q <= dwvg_pkg::IDX_NONE;
			col_q <= dwvg_pkg::IDX_NONE;
		end
		case (st_q)
			dwvg_pkg::ST_MUL_BRAKE: begin
				mul_q <= mul_p;
			end
			dwvg_pkg::ST_MUL_ACCEL: begin
				delta_brake_q <= mul_q[PF+LW-1:PF];
				mul_q         <= mul_p;
			end
			dwvg_pkg::ST_MUL_TURN: begin
				delta_accel_q <= mul_q[PF+LW-1:PF];
				mul_q         <= mul_p;
			end
			dwvg_pkg::ST_CHECK: begin
				err_q <= query_err;
				row_q <= speed_flat ? dwvg_pkg::IDX_ZERO : dwvg_pkg::IDX_NONE;
				col_q <= turn_flat ? dwvg_pkg::IDX_ZERO : dwvg_pkg::IDX_NONE;
			end
			dwvg_pkg::ST_ROW_MUL, dwvg_pkg::ST_COL_MUL: begin
				mul_q <= mul_p;
			end
			dwvg_pkg::ST_WAIT_ROW: begin
				if (div_rsp.done) begin
					row_q <= $signed({1'b0, div_rsp.quo[dwvg_pkg::DIV_NARROW_W-1:0]});
				end
			end
			dwvg_pkg::ST_WAIT_COL: begin
				if (div_rsp.done) begin
					col_q <= $signed({1'b0, div_rsp.quo[dwvg_pkg::DIV_NARROW_W-1:0]});
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			speed_low       <= win_low_q;
			speed_high      <= win_high_q;
			turn_left       <= win_left_q;
			turn_right      <= win_right_q;
			speed_increment <= step_speed_q;
			turn_increment  <= step_turn_q;
			grid_rows       <= rows_q;
			grid_cols       <= cols_q;
			row_index       <= row_q;
			col_index       <= col_q;
			outside_window  <= err_q;
		end
	end

	assign out_valid = out_valid_q;

	a_speed_order: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != dwvg_pkg::ST_ORDER) |-> (win_high_q >= win_low_q))
		else $error("linear window inverted outside ordering step");

	a_turn_order: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != dwvg_pkg::ST_ORDER) |-> (win_right_q >= win_left_q))
		else $error("angular window inverted outside ordering step");

	a_counts_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(rows_q != '0) && (cols_q != '0))
		else $error("grid count dropped to zero");

	a_load_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || !out_stall))
		else $error("result overwritten while pending");

endmodule

`default_nettype wire

@@ rtl/core/dynamic_window_velocity_grid_core.sv @@
// ----------------------------------------------------------------------------
// dynamic_window_velocity_grid_core - dynamic window and velocity grid
// Keeps the reachable speed window and a grid over it; maps candidates to
// grid cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): a request with kind = 0 updates the
//   window from measured speeds, kind = 1 maps a candidate (v, omega) to grid
//   indices. Every request yields exactly one result on the output channel
//   (out_valid / out_stall), in order.
//   Configuration: write cfg_data to register cfg_index while cfg_we is high;
//   write only while no request is in flight.
//   The back-end runs each request through the shared one-bit-per-cycle
//   divider: 33 quotient bits for each step size, 11 for each grid index; a
//   query skips the division on a degenerate axis or outside the window. The
//   back-end takes one request at a time and pops another only once the last
//   result is loaded into the output register.
//   The intake stage plus a two-entry queue accept up to three requests ahead
//   of the back-end; a pending result in the output register does not block
//   intake. When the receiver stalls, the result holds and the back-end waits
//   after finishing its next request; intake stalls once the queue is full.
//   Reset clears the window, step sizes and grid counts (counts to 1) and
//   loads the register defaults (bins 100, period 655).
// ----------------------------------------------------------------------------
`default_nettype none

module dynamic_window_velocity_grid_core #(
	parameter int QUEUE_DEPTH = dwvg_pkg::QUEUE_DEPTH
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,

	input  wire logic                                   cfg_we,
	input  wire logic [dwvg_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [dwvg_pkg::CFG_W-1:0]             cfg_data,

	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic                                   kind,
	input  wire logic signed [dwvg_pkg::SPEED_W-1:0]    linear_speed,
	input  wire logic signed [dwvg_pkg::SPEED_W-1:0]    angular_speed,

	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic signed [dwvg_pkg::SPEED_W-1:0]         speed_low,
	output logic signed [dwvg_pkg::SPEED_W-1:0]         speed_high,
	output logic signed [dwvg_pkg::SPEED_W-1:0]         turn_left,
	output logic signed [dwvg_pkg::SPEED_W-1:0]         turn_right,
	output logic        [dwvg_pkg::STEP_W-1:0]          speed_increment,
	output logic        [dwvg_pkg::STEP_W-1:0]          turn_increment,
	output logic        [dwvg_pkg::BINS_W-1:0]          grid_rows,
	output logic        [dwvg_pkg::BINS_W-1:0]          grid_cols,
	output logic signed [dwvg_pkg::IDX_W-1:0]           row_index,
	output logic signed [dwvg_pkg::IDX_W-1:0]           col_index,
	output logic                                        outside_window
);

	// Configuration registers
	logic [dwvg_pkg::LIMIT_W-1:0]  accel_q, brake_q, fwd_q, tlim_q, taccel_q;
	logic [dwvg_pkg::BINS_W-1:0]   speed_bins_q, turn_bins_q;
	logic [dwvg_pkg::PERIOD_W-1:0] period_q;

	dwvg_pkg::cfg_t    cfg;
	dwvg_pkg::q_stat_t q_stat;
	dwvg_pkg::op_t     push_data;
	dwvg_pkg::op_t     pop_data;
	logic              push;
	logic              pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_q      <= '0;
			brake_q      <= '0;
			fwd_q        <= '0;
			tlim_q       <= '0;
			taccel_q     <= '0;
			speed_bins_q <= dwvg_pkg::BINS_RST;
			turn_bins_q  <= dwvg_pkg::BINS_RST;
			period_q     <= dwvg_pkg::PERIOD_RST;
		end else if (cfg_we) begin
			case (dwvg_pkg::cfg_reg_t'(cfg_index))
				dwvg_pkg::REG_ACCEL:      accel_q      <= cfg_data;
				dwvg_pkg::REG_BRAKE:      brake_q      <= cfg_data;
				dwvg_pkg::REG_FORWARD:    fwd_q        <= cfg_data;
				dwvg_pkg::REG_TURN_RATE:  tlim_q       <= cfg_data;
				dwvg_pkg::REG_TURN_ACCEL: taccel_q     <= cfg_data;
				dwvg_pkg::REG_SPEED_BINS: speed_bins_q <= cfg_data[dwvg_pkg::BINS_W-1:0];
				dwvg_pkg::REG_TURN_BINS:  turn_bins_q  <= cfg_data[dwvg_pkg::BINS_W-1:0];
				dwvg_pkg::REG_PERIOD:     period_q     <= cfg_data[dwvg_pkg::PERIOD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Bin counts go out already forced into [1, MAX_BINS]
	always_comb begin
		cfg.accel      = accel_q;
		cfg.brake      = brake_q;
		cfg.fwd        = fwd_q;
		cfg.tlim       = tlim_q;
		cfg.taccel     = taccel_q;
		cfg.speed_bins = dwvg_pkg::eff_bins(speed_bins_q);
		cfg.turn_bins  = dwvg_pkg::eff_bins(turn_bins_q);
		cfg.period     = period_q;
	end

	// Intake: register, classify and clamp a request
	dwvg_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.linear_speed  (linear_speed),
		.angular_speed (angular_speed),
		.cfg           (cfg),
		.q_stat        (q_stat),
		.push          (push),
		.push_data     (push_data)
	);

	// Decouple intake from the sequencer
	dwvg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	// Window update, grid lookup and result register
	dwvg_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.q_data          (pop_data),
		.q_stat          (q_stat),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.speed_low       (speed_low),
		.speed_high      (speed_high),
		.turn_left       (turn_left),
		.turn_right      (turn_right),
		.speed_increment (speed_increment),
		.turn_increment  (turn_increment),
		.grid_rows       (grid_rows),
		.grid_cols       (grid_cols),
		.row_index       (row_index),
		.col_index       (col_index),
		.outside_window  (outside_window)
	);

endmodule

`default_nettype wire

@@ dv/dwvg_grid_monitor.sv @@
// ----------------------------------------------------------------------------
// dwvg_grid_monitor - result predictor and comparator for the grid core
// Watches the configuration port and both handshake channels, keeps its own
// copy of the speed window and the grid, and compares every result with the
// oldest predicted one, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module dwvg_grid_monitor (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [dwvg_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [dwvg_pkg::CFG_W-1:0]             cfg_data,
	input  wire logic                                   in_valid,
	input  wire logic                                   in_stall,
	input  wire logic                                   kind,
	input  wire logic signed [dwvg_pkg::SPEED_W-1:0]    linear_speed,
	input  wire logic signed [dwvg_pkg::SPEED_W-1:0]    angular_speed,
	input  wire logic                                   out_valid,
	input  wire logic                                   out_stall,
	input  wire logic signed [dwvg_pkg::SPEED_W-1:0]    speed_low,
	input  wire logic signed [dwvg_pkg::SPEED_W-1:0]    speed_high,
	input  wire logic signed [dwvg_pkg::SPEED_W-1:0]    turn_left,
	input  wire logic signed [dwvg_pkg::SPEED_W-1:0]    turn_right,
	input  wire logic        [dwvg_pkg::STEP_W-1:0]     speed_increment,
	input  wire logic        [dwvg_pkg::STEP_W-1:0]     turn_increment,
	input  wire logic        [dwvg_pkg::BINS_W-1:0]     grid_rows,
	input  wire logic        [dwvg_pkg::BINS_W-1:0]     grid_cols,
	input  wire logic signed [dwvg_pkg::IDX_W-1:0]      row_index,
	input  wire logic signed [dwvg_pkg::IDX_W-1:0]      col_index,
	input  wire logic                                   outside_window,
	output int                                          mismatches,
	output int                                          outstanding,
	output longint                                      span_v_low,
	output longint                                      span_v_high,
	output longint                                      span_w_low,
	output longint                                      span_w_high
);
	timeunit 1ns;
	timeprecision 1ps;

	import dwvg_pkg::*;

	localparam longint STEP_MAX = 64'h7FFF_FFFF;

	typedef struct packed {
		logic signed [SPEED_W-1:0] v_low;
		logic signed [SPEED_W-1:0] v_high;
		logic signed [SPEED_W-1:0] w_left;
		logic signed [SPEED_W-1:0] w_right;
		logic        [STEP_W-1:0]  v_step;
		logic        [STEP_W-1:0]  w_step;
		logic        [BINS_W-1:0]  rows;
		logic        [BINS_W-1:0]  cols;
		logic signed [IDX_W-1:0]   row;
		logic signed [IDX_W-1:0]   col;
		logic                      off;
	} grid_result_t;

	// Register copy, reset values
	longint accel_lim = 0;
	longint brake_lim = 0;
	longint fwd_lim = 0;
	longint turn_lim = 0;
	longint turn_acc_lim = 0;
	logic [BINS_W-1:0]   speed_div = BINS_RST;
	logic [BINS_W-1:0]   turn_div = BINS_RST;
	logic [PERIOD_W-1:0] period = PERIOD_RST;

	// Window and grid copy: window cleared, counts one
	longint win_lo = 0;
	longint win_hi = 0;
	longint win_left = 0;
	longint win_right = 0;
	longint step_v = 0;
	longint step_w = 0;
	longint n_rows = 1;
	longint n_cols = 1;

	grid_result_t expected_grids[$];

	assign span_v_low  = win_lo;
	assign span_v_high = win_hi;
	assign span_w_low  = win_left;
	assign span_w_high = win_right;

	function automatic longint divisions_used(logic [BINS_W-1:0] b);
		if (b == '0) begin
			return 1;
		end
		if (b > BINS_W'(MAX_BINS)) begin
			return MAX_BINS;
		end
		return longint'(b);
	endfunction

	// Speed change reachable in one period, truncated
	function automatic longint scaled(longint lim);
		return (lim * longint'(period)) >>> PERIOD_FRAC;
	endfunction

	function automatic longint clip(longint x, longint lo, longint hi);
		if (x < lo) begin
			return lo;
		end
		if (x > hi) begin
			return hi;
		end
		return x;
	endfunction

	function automatic longint grid_slot(longint x, longint lo, longint hi, longint n);
		return ((x - lo) * n) / (hi - lo);
	endfunction

	function automatic grid_result_t predict_grid(op_kind_t op, longint v, longint w);
		grid_result_t r;
		longint vb, wb, lo, hi, wl, wr, dt, row, col;
		logic vdeg, wdeg, off;
		vb = divisions_used(speed_div);
		wb = divisions_used(turn_div);
		row = -1;
		col = -1;
		off = 1'b0;
		if (op == OP_UPDATE) begin
			if (v < 0) begin
				v = 0;
			end
			v = clip(v, 0, fwd_lim);
			w = clip(w, -turn_lim, turn_lim);
			lo = clip(v - scaled(brake_lim), 0, fwd_lim);
			hi = clip(v + scaled(accel_lim), 0, fwd_lim);
			if (hi < lo) begin
				hi = lo;
			end
			dt = scaled(turn_acc_lim);
			wr = (w + dt > turn_lim) ? turn_lim : w + dt;
			wl = (w - dt < -turn_lim) ? -turn_lim : w - dt;
			if (wr < wl) begin
				wr = wl;
			end
			win_lo = lo;
			win_hi = hi;
			win_left = wl;
			win_right = wr;
			step_v = (hi - lo) / vb;
			step_w = (wr - wl) / wb;
			if (step_w > STEP_MAX) begin
				step_w = STEP_MAX;
			end
			n_rows = (step_v > 0 && hi > lo) ? vb : 1;
			n_cols = (step_w > 0 && wr > wl) ? wb : 1;
		end else begin
			vdeg = (win_hi == win_lo);
			wdeg = (win_right == win_left);
			off = (!vdeg && (v < win_lo || v > win_hi)) ||
				(!wdeg && (w < win_left || w > win_right));
			if (vdeg) begin
				row = 0;
			end else if (!off) begin
				row = grid_slot(v, win_lo, win_hi, vb);
			end
			if (wdeg) begin
				col = 0;
			end else if (!off) begin
				col = grid_slot(w, win_left, win_right, wb);
			end
		end
		r.v_low   = win_lo[SPEED_W-1:0];
		r.v_high  = win_hi[SPEED_W-1:0];
		r.w_left  = win_left[SPEED_W-1:0];
		r.w_right = win_right[SPEED_W-1:0];
		r.v_step  = step_v[STEP_W-1:0];
		r.w_step  = step_w[STEP_W-1:0];
		r.rows    = n_rows[BINS_W-1:0];
		r.cols    = n_cols[BINS_W-1:0];
		r.row     = row[IDX_W-1:0];
		r.col     = col[IDX_W-1:0];
		r.off     = off;
		return r;
	endfunction

	function automatic int field_check(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	function automatic int compare_grid(grid_result_t want, grid_result_t got);
		int bad;
		bad = 0;
		bad += field_check("speed_low", want.v_low, got.v_low);
		bad += field_check("speed_high", want.v_high, got.v_high);
		bad += field_check("turn_left", want.w_left, got.w_left);
		bad += field_check("turn_right", want.w_right, got.w_right);
		bad += field_check("speed_increment", want.v_step, got.v_step);
		bad += field_check("turn_increment", want.w_step, got.w_step);
		bad += field_check("grid_rows", want.rows, got.rows);
		bad += field_check("grid_cols", want.cols, got.cols);
		bad += field_check("row_index", want.row, got.row);
		bad += field_check("col_index", want.col, got.col);
		bad += field_check("outside_window", want.off, got.off);
		return bad;
	endfunction

	always @(posedge clk) begin
		grid_result_t got;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_ACCEL:      accel_lim = longint'(cfg_data);
					REG_BRAKE:      brake_lim = longint'(cfg_data);
					REG_FORWARD:    fwd_lim = longint'(cfg_data);
					REG_TURN_RATE:  turn_lim = longint'(cfg_data);
					REG_TURN_ACCEL: turn_acc_lim = longint'(cfg_data);
					REG_SPEED_BINS: speed_div = cfg_data[BINS_W-1:0];
					REG_TURN_BINS:  turn_div = cfg_data[BINS_W-1:0];
					REG_PERIOD:     period = cfg_data[PERIOD_W-1:0];
					default: ;
				endcase
			end
			// Retire the oldest prediction before queuing a new one
			if (out_valid && !out_stall) begin
				got = '{speed_low, speed_high, turn_left, turn_right,
					speed_increment, turn_increment, grid_rows, grid_cols,
					row_index, col_index, outside_window};
				if (expected_grids.size() == 0) begin
					$display("%0t ns: result with no request pending", $time);
					mismatches++;
				end else begin
					mismatches += compare_grid(expected_grids.pop_front(), got);
				end
			end
			if (in_valid && !in_stall) begin
				expected_grids.push_back(predict_grid(op_kind_t'(kind),
					longint'(linear_speed), longint'(angular_speed)));
			end
			outstanding = expected_grids.size();
		end
	end

endmodule

`default_nettype wire

@@ dv/tb_dynamic_window_velocity_grid_core.sv @@
// ----------------------------------------------------------------------------
// tb_dynamic_window_velocity_grid_core - testbench of the velocity grid core
// Drives directed and random update and query requests through the window
// core under random idling on both channels, reprograms the limits between
// bursts, and lets the grid monitor check every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_dynamic_window_velocity_grid_core;
	timeunit 1ns;
	timeprecision 1ps;

	import dwvg_pkg::*;

	// Cycles without any handshake before the run is declared hung
	localparam int HANG_LIMIT = 4000;
	// Random bursts, each under its own register setting
	localparam int BURSTS = 10;
	localparam int BURST_LEN = 200;
	// Quiet cycles after the last result, above the update latency
	localparam int TAIL_CYCLES = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                         cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]         cfg_index = REG_ACCEL;
	logic [CFG_W-1:0]             cfg_data = '0;

	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic                         kind = OP_UPDATE;
	logic signed [SPEED_W-1:0]    linear_speed = '0;
	logic signed [SPEED_W-1:0]    angular_speed = '0;

	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic signed [SPEED_W-1:0]    speed_low;
	logic signed [SPEED_W-1:0]    speed_high;
	logic signed [SPEED_W-1:0]    turn_left;
	logic signed [SPEED_W-1:0]    turn_right;
	logic        [STEP_W-1:0]     speed_increment;
	logic        [STEP_W-1:0]     turn_increment;
	logic        [BINS_W-1:0]     grid_rows;
	logic        [BINS_W-1:0]     grid_cols;
	logic signed [IDX_W-1:0]      row_index;
	logic signed [IDX_W-1:0]      col_index;
	logic                         outside_window;

	int     mismatches;
	int     outstanding;
	longint span_v_low;
	longint span_v_high;
	longint span_w_low;
	longint span_w_high;

	// Stimulus bookkeeping: no idling while quiet is set
	logic   quiet = 1'b0;
	int     stall_run = 0;
	int     hang_cycles = 0;
	longint cur_fwd = 0;
	longint cur_tlim = 0;

	dynamic_window_velocity_grid_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.kind            (kind),
		.linear_speed    (linear_speed),
		.angular_speed   (angular_speed),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.speed_low       (speed_low),
		.speed_high      (speed_high),
		.turn_left       (turn_left),
		.turn_right      (turn_right),
		.speed_increment (speed_increment),
		.turn_increment  (turn_increment),
		.grid_rows       (grid_rows),
		.grid_cols       (grid_cols),
		.row_index       (row_index),
		.col_index       (col_index),
		.outside_window  (outside_window)
	);

	dwvg_grid_monitor monitor (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.kind            (kind),
		.linear_speed    (linear_speed),
		.angular_speed   (angular_speed),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.speed_low       (speed_low),
		.speed_high      (speed_high),
		.turn_left       (turn_left),
		.turn_right      (turn_right),
		.speed_increment (speed_increment),
		.turn_increment  (turn_increment),
		.grid_rows       (grid_rows),
		.grid_cols       (grid_cols),
		.row_index       (row_index),
		.col_index       (col_index),
		.outside_window  (outside_window),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.span_v_low      (span_v_low),
		.span_v_high     (span_v_high),
		.span_w_low      (span_w_low),
		.span_w_high     (span_w_high)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Receiver: stall now and then, sometimes for a run of cycles, so that
	// a held result meets the back-end in different states of its sequencer
	always @(posedge clk) begin
		if (stall_run != 0) begin
			stall_run <= stall_run - 1;
		end else if (!quiet && $urandom_range(0, 99) < 8) begin
			out_stall <= 1'b1;
			stall_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(1, 12) : 0;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Watchdog: count cycles in which neither channel moves a request
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			hang_cycles <= 0;
		end else if (hang_cycles >= HANG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			hang_cycles <= hang_cycles + 1;
		end
	end

	// Present one request and hold it until accepted; valid stays high so a
	// following request can go out back to back
	task automatic send_request(op_kind_t k, logic [31:0] v, logic [31:0] w);
		if (!quiet && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		linear_speed <= v;
		angular_speed <= w;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid and hold off until every predicted result has come back
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(cfg_reg_t r, logic [CFG_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= d;
		@(posedge clk);
	endtask

	// Rewrite every register with the core idle
	task automatic program_window(logic [LIMIT_W-1:0] accel, logic [LIMIT_W-1:0] brake,
		logic [LIMIT_W-1:0] fwd, logic [LIMIT_W-1:0] tlim, logic [LIMIT_W-1:0] taccel,
		logic [BINS_W-1:0] sbins, logic [BINS_W-1:0] tbins, logic [PERIOD_W-1:0] per);
		settle();
		put_reg(REG_ACCEL, CFG_W'(accel));
		put_reg(REG_BRAKE, CFG_W'(brake));
		put_reg(REG_FORWARD, CFG_W'(fwd));
		put_reg(REG_TURN_RATE, CFG_W'(tlim));
		put_reg(REG_TURN_ACCEL, CFG_W'(taccel));
		put_reg(REG_SPEED_BINS, CFG_W'(sbins));
		put_reg(REG_TURN_BINS, CFG_W'(tbins));
		put_reg(REG_PERIOD, CFG_W'(per));
		cfg_we <= 1'b0;
		cur_fwd = longint'(fwd);
		cur_tlim = longint'(tlim);
	endtask

	// Limits: mostly a few m/s, with zero, full scale and tiny raw values
	function automatic logic [LIMIT_W-1:0] pick_limit();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return LIMIT_W'($urandom_range(0, 255));
			default: return LIMIT_W'($urandom_range(0, 32'h0008_0000));
		endcase
	endfunction

	// Bin counts: mostly small so that indices are easy to hit, plus zero and
	// the saturating values
	function automatic logic [BINS_W-1:0] pick_divisions();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return BINS_W'(MAX_BINS);
			3: return BINS_W'(MAX_BINS + 1);
			4: return BINS_W'(1);
			5: return BINS_W'($urandom_range(2, MAX_BINS));
			default: return BINS_W'($urandom_range(1, 16));
		endcase
	endfunction

	// A speed around [lo, hi]: the edges, one step past them, anything at
	// all, or mostly a point inside
	function automatic logic [31:0] pick_point(longint lo, longint hi);
		longint span;
		span = hi - lo + 1;
		case ($urandom_range(0, 9))
			0: return lo[31:0];
			1: return hi[31:0];
			2: return 32'(lo - 1);
			3: return 32'(hi + 1);
			4, 5: return $urandom;
			default: return 32'(lo + longint'({$urandom, $urandom} % 64'(span)));
		endcase
	endfunction

	task automatic reshape(int burst);
		logic [PERIOD_W-1:0] per;
		if (burst == 1) begin
			per = PERIOD_W'(1);
		end else if (burst == 2) begin
			per = '1;
		end else begin
			per = PERIOD_W'($urandom_range(1, 65535));
		end
		program_window(pick_limit(), pick_limit(), pick_limit(), pick_limit(), pick_limit(),
			pick_divisions(), pick_divisions(), per);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset state: both axes degenerate, indices zero
		send_request(OP_QUERY, 32'h0001_0000, 32'hFFFF_0000);
		send_request(OP_UPDATE, 32'h0000_0000, 32'h0000_0000);

		// Plain window: 0.5 up, 1.0 down, 0.75 turn per quarter second
		program_window(31'h0002_0000, 31'h0004_0000, 31'h0002_0000, 31'h0001_8000,
			31'h0003_0000, 11'd10, 11'd7, 16'h4000);
		send_request(OP_UPDATE, 32'h0001_0000, 32'h0000_0000);
		send_request(OP_QUERY, 32'h0000_0000, 32'hFFFF_4000);  // bottom corner
		send_request(OP_QUERY, 32'h0001_8000, 32'h0000_C000);  // top corner hits bins
		send_request(OP_QUERY, 32'h0000_B333, 32'h0000_199A);
		send_request(OP_QUERY, 32'h0002_0000, 32'h0000_0000);  // speed past the top
		send_request(OP_QUERY, 32'hFFFF_0000, 32'h0005_0000);  // both axes outside
		send_request(OP_UPDATE, 32'hFFFD_0000, 32'hFFF7_0000); // reverse speed, hard turn
		send_request(OP_UPDATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF); // clamp to the limits
		send_request(OP_UPDATE, 32'h8000_0000, 32'h8000_0000);
		send_request(OP_QUERY, 32'h7FFF_FFFF, 32'h8000_0000);

		// No linear acceleration: the speed axis collapses to a point
		program_window(31'h0, 31'h0, 31'h0002_0000, 31'h0001_8000,
			31'h0000_8000, 11'd0, 11'd3, 16'hFFFF);
		send_request(OP_UPDATE, 32'h0001_0000, 32'h0000_0000);
		send_request(OP_QUERY, 32'h0005_0000, 32'h0000_199A);
		send_request(OP_QUERY, 32'h0005_0000, 32'h0009_0000);  // turn outside, row still 0
		send_request(OP_QUERY, 32'h0001_0000, 32'h0000_0000);

		// Full-scale turn limits with one bin: the turn step saturates
		program_window(31'd3, 31'h0, '1, '1, '1, 11'd0, 11'd1, 16'hFFFF);
		send_request(OP_UPDATE, 32'h0000_0000, 32'h0000_0000);
		send_request(OP_QUERY, 32'h0000_0001, 32'h0000_0000);
		send_request(OP_QUERY, 32'h0000_0002, 32'h7FFF_FFFF);
		send_request(OP_QUERY, 32'h0000_0002, 32'h7FFF_0000);

		// Oversized bin counts saturate
		program_window(31'h0001_0000, 31'h0001_0000, '1, '1, 31'h0001_0000,
			11'd2047, 11'd1025, 16'hFFFF);
		send_request(OP_UPDATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_request(OP_QUERY, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_request(OP_QUERY, 32'h8000_0000, 32'h8000_0000);
		send_request(OP_QUERY, 32'h7FFF_8000, 32'h7FFF_8000);

		// Random bursts: updates reshape the window, queries aim at the
		// window currently predicted
		for (int b = 0; b < BURSTS; b++) begin
			reshape(b);
			quiet = (b == 4);
			for (int n = 0; n < BURST_LEN; n++) begin
				// Once, let the pipeline run dry in the middle of a burst
				if (b == 6 && n == BURST_LEN / 2) begin
					settle();
				end
				if ($urandom_range(0, 9) < 3) begin
					send_request(OP_UPDATE, pick_point(0, cur_fwd),
						pick_point(-cur_tlim, cur_tlim));
				end else begin
					send_request(OP_QUERY, pick_point(span_v_low, span_v_high),
						pick_point(span_w_low, span_w_high));
				end
			end
			quiet = 1'b0;
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ dynamic_window_velocity_grid_core.f @@
rtl/core/dwvg_pkg.sv
rtl/core/dwvg_front.sv
rtl/core/dwvg_queue.sv
rtl/core/dwvg_div.sv
rtl/core/dwvg_back.sv
rtl/core/dynamic_window_velocity_grid_core.sv
dv/dwvg_grid_monitor.sv
dv/tb_dynamic_window_velocity_grid_core.sv
